// ===== src/sis_pkg.sv =====
package sis_pkg;

  // default depth of the used-sector map
  localparam int MAX_SECTORS_DEF = 64;
  // head count clamp for the block address
  localparam int MAX_HEADS = 16;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [6:0] SPT_RST   = 7'd17;
  localparam logic [5:0] STEP_RST  = 6'd1;
  localparam logic [5:0] SKEW_RST  = 6'd0;
  localparam logic [4:0] HEADS_RST = 5'd4;

  // stream payload widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_NEW_CYL   = 2'd0,
    OP_NEW_TRACK = 2'd1,
    OP_ADVANCE   = 2'd2
  } op_t;

  // register indexes
  typedef enum logic [1:0] {
    REG_SPT   = 2'd0,
    REG_STEP  = 2'd1,
    REG_SKEW  = 2'd2,
    REG_HEADS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] sectors_per_track;
    logic [5:0] sector_step;
    logic [5:0] track_skew;
    logic [4:0] heads_per_cylinder;
  } cfg_t;

  // sector index width
  function automatic int sec_w(int max_sec);
    return $clog2(max_sec);
  endfunction

  // width that holds a count up to the map depth
  function automatic int cnt_w(int max_sec);
    return $clog2(max_sec + 1);
  endfunction

  // dividend width of the remainder unit: a sector index plus a 6-bit distance
  function automatic int dvd_w(int max_sec);
    return (($clog2(max_sec) > 6) ? $clog2(max_sec) : 6) + 1;
  endfunction

endpackage

// ===== src/sis_cfg_regs.sv =====
module sis_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sis_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sis_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sis_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output sis_pkg::cfg_t                     cfg
);
  import sis_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sectors_per_track  <= SPT_RST;
      cfg.sector_step        <= STEP_RST;
      cfg.track_skew         <= SKEW_RST;
      cfg.heads_per_cylinder <= HEADS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPT:   cfg.sectors_per_track  <= pwdata[6:0];
        REG_STEP:  cfg.sector_step        <= pwdata[5:0];
        REG_SKEW:  cfg.track_skew         <= pwdata[5:0];
        REG_HEADS: cfg.heads_per_cylinder <= pwdata[4:0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_SPT:   prdata = CFG_DATA_W'(cfg.sectors_per_track);
      REG_STEP:  prdata = CFG_DATA_W'(cfg.sector_step);
      REG_SKEW:  prdata = CFG_DATA_W'(cfg.track_skew);
      REG_HEADS: prdata = CFG_DATA_W'(cfg.heads_per_cylinder);
    endcase
  end

endmodule

// ===== src/sis_mod_unit.sv =====
module sis_mod_unit #(
  parameter int MAX_SECTORS = sis_pkg::MAX_SECTORS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [sis_pkg::dvd_w(MAX_SECTORS)-1:0]     dividend,
  input  logic [sis_pkg::cnt_w(MAX_SECTORS)-1:0]     divisor,
  output logic                                       done,
  output logic [sis_pkg::sec_w(MAX_SECTORS)-1:0]     result
);
  import sis_pkg::*;

  localparam int SW   = sec_w(MAX_SECTORS);
  localparam int CW   = cnt_w(MAX_SECTORS);
  localparam int DW   = dvd_w(MAX_SECTORS);
  localparam int CNTW = $clog2(DW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   rem;
  logic [DW-1:0]   dvd;
  logic [CW-1:0]   dvs;
  logic [CW:0]     trial;
  logic [CW:0]     diff;
  logic [CW-1:0]   rem_step;

  // one restoring step: shift in a dividend bit, subtract the divisor if it fits
  always_comb begin
    trial    = {rem, dvd[DW-1]};
    diff     = trial - {1'b0, dvs};
    rem_step = (trial >= {1'b0, dvs}) ? diff[CW-1:0] : trial[CW-1:0];
  end

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_step;
      dvd <= {dvd[DW-2:0], 1'b0};
    end
  end

  assign result = rem[SW-1:0];

endmodule

// ===== src/sis_core.sv =====
module sis_core #(
  parameter int MAX_SECTORS = sis_pkg::MAX_SECTORS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  sis_pkg::cfg_t                              cfg,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [sis_pkg::IN_DATA_W-1:0]              s_tdata,
  input  logic [sis_pkg::IN_USER_W-1:0]              s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [sis_pkg::OUT_DATA_W-1:0]             m_tdata,
  output logic                                       m_tlast,
  output logic                                       mod_start,
  output logic [sis_pkg::dvd_w(MAX_SECTORS)-1:0]     mod_dividend,
  output logic [sis_pkg::cnt_w(MAX_SECTORS)-1:0]     mod_divisor,
  input  logic                                       mod_done,
  input  logic [sis_pkg::sec_w(MAX_SECTORS)-1:0]     mod_result
);
  import sis_pkg::*;

  localparam int SW = sec_w(MAX_SECTORS);
  localparam int CW = cnt_w(MAX_SECTORS);
  localparam int DW = dvd_w(MAX_SECTORS);
  localparam int PW = 18;
  localparam int MW = 32;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CUR   = 8'b00000010,
    S_NEXT  = 8'b00000100,
    S_PROBE = 8'b00001000,
    S_MUL_A = 8'b00010000,
    S_MUL_B = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_CLEAR = 8'b10000000
  } state_t;

  state_t                 state;
  logic                   used_mem [MAX_SECTORS];
  logic                   used_rd;
  logic [SW-1:0]          clr_addr;
  logic [CW-1:0]          used_total;
  logic [SW-1:0]          sector_now;
  logic [SW-1:0]          track_first;
  op_t                    op_r;
  logic [11:0]            cyl_r;
  logic [3:0]             head_r;
  logic [SW-1:0]          cur_r;
  logic [CW-1:0]          probe_k;
  logic [PW-1:0]          prod_a;
  logic [21:0]            lba_r;

  logic          accept;
  op_t           op_in;
  logic [CW-1:0] n;
  logic [4:0]    heads_eff;
  logic [CW-1:0] total_inc;
  logic [CW-1:0] cur_plus;
  logic [SW-1:0] cur_wrap;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [SW-1:0] mem_raddr;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign op_in    = op_t'(s_tuser);

  // effective sector and head counts
  always_comb begin
    if (cfg.sectors_per_track == 7'd0) begin
      n = CW'(1);
    end else if (32'(cfg.sectors_per_track) > MAX_SECTORS) begin
      n = CW'(MAX_SECTORS);
    end else begin
      n = CW'(cfg.sectors_per_track);
    end
    heads_eff = (32'(cfg.heads_per_cylinder) > MAX_HEADS) ? 5'(MAX_HEADS)
                                                         : cfg.heads_per_cylinder;
  end

  assign mod_divisor = n;
  assign total_inc   = (used_total < n) ? used_total + CW'(1) : used_total;
  assign cur_plus    = CW'(cur_r) + CW'(1);
  assign cur_wrap    = (cur_plus == n) ? '0 : cur_plus[SW-1:0];

  // launches of the shared remainder unit
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = '0;
    if (accept) begin
      if (op_in == OP_NEW_TRACK) begin
        mod_start    = (cfg.track_skew != 6'd0);
        mod_dividend = DW'(track_first);
      end else begin
        mod_start    = 1'b1;
        mod_dividend = DW'(sector_now);
      end
    end else if (state == S_CUR && mod_done) begin
      if (op_r == OP_NEW_TRACK) begin
        mod_start    = 1'b1;
        mod_dividend = DW'(mod_result) + DW'(cfg.track_skew);
      end else if (op_r == OP_ADVANCE && total_inc < n) begin
        mod_start    = 1'b1;
        mod_dividend = DW'(mod_result) + DW'(cfg.sector_step);
      end
    end
  end

  // used map ports: clearing pass, mark on advance, probe read one sector ahead
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mod_result;
    mem_wdata = 1'b1;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 1'b0;
    end else if (state == S_CUR && mod_done && op_r == OP_ADVANCE) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state == S_PROBE) ? cur_wrap : mod_result;

  // used-sector map
  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_waddr] <= mem_wdata;
    end
    used_rd <= used_mem[mem_raddr];
  end

  // sequencer and track state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      used_total  <= '0;
      sector_now  <= '0;
      track_first <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // result taken by the receiver
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_r   <= op_in;
            cyl_r  <= s_tdata[11:0];
            head_r <= s_tdata[15:12];
            if (op_in == OP_NEW_CYL) begin
              track_first <= '0;
              state       <= S_CUR;
            end else if (op_in == OP_NEW_TRACK) begin
              used_total <= '0;
              if (cfg.track_skew == 6'd0) begin
                sector_now <= '0;
                cur_r      <= '0;
                state      <= S_MUL_A;
              end else begin
                state <= S_CUR;
              end
            end else begin
              state <= S_CUR;
            end
          end
        end
        S_CUR: begin
          if (mod_done) begin
            cur_r <= mod_result;
            if (op_r == OP_NEW_TRACK) begin
              sector_now <= mod_result;
              state      <= S_NEXT;
            end else if (op_r == OP_ADVANCE) begin
              used_total <= total_inc;
              if (total_inc < n) begin
                state <= S_NEXT;
              end else begin
                sector_now <= mod_result;
                state      <= S_MUL_A;
              end
            end else begin
              state <= S_MUL_A;
            end
          end
        end
        S_NEXT: begin
          if (mod_done) begin
            if (op_r == OP_NEW_TRACK) begin
              track_first <= mod_result;
              state       <= S_MUL_A;
            end else begin
              cur_r   <= mod_result;
              probe_k <= '0;
              state   <= S_PROBE;
            end
          end
        end
        // walk forward past used sectors, at most one full turn
        S_PROBE: begin
          if (probe_k < n && used_rd) begin
            cur_r   <= cur_wrap;
            probe_k <= probe_k + CW'(1);
          end else begin
            sector_now <= cur_r;
            state      <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          prod_a <= PW'(cyl_r) * PW'(heads_eff) + PW'(head_r);
          state  <= S_MUL_B;
        end
        S_MUL_B: begin
          lba_r <= 22'(MW'(prod_a) * MW'(n) + MW'(cur_r));
          state <= S_OUT;
        end
        // hand over once the output register is free
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, lba_r, 6'(cur_r)};
            m_tlast  <= (used_total >= n);
            if (op_r == OP_NEW_TRACK) begin
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        // clear the whole used map, one entry a cycle
        S_CLEAR: begin
          if (clr_addr == SW'(MAX_SECTORS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + SW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an operation is in flight");

  a_mod_done_expected: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_CUR || state == S_NEXT))
    else $error("remainder result with no pass waiting for it");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> probe_k <= n)
    else $error("probe ran past one full turn");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL_A |-> CW'(cur_r) < n)
    else $error("selected sector outside the track");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && m_tvalid && !m_tready |=> state == S_OUT)
    else $error("result dropped while output stalled");
`endif

endmodule

// ===== src/sector_interleave_sequencer.sv =====
// timing: set by the shared remainder unit (one bit a cycle, 7-bit dividend at 64 sectors) and
//   the used-map probe (one sector a cycle); a new track with zero skew uses neither
// flow: one transaction at a time; the input is ready again as the result is offered,
//   but a new track first runs a clearing pass of the used map
// reset: synchronous active high; registers to defaults, counts and sector cleared at once, then
//   a clearing pass over the used map before the first transaction
module sector_interleave_sequencer #(
  parameter int MAX_SECTORS = sis_pkg::MAX_SECTORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // cylinder [11:0], head_number [15:12]
  input  logic [sis_pkg::IN_DATA_W-1:0]     s_tdata,
  // operation [1:0]
  input  logic [sis_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // current_sector [5:0], block_address [27:6], zero [31:28]
  output logic [sis_pkg::OUT_DATA_W-1:0]    m_tdata,
  // track_done
  output logic                              m_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sis_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sis_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sis_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import sis_pkg::*;

  localparam int SW = sec_w(MAX_SECTORS);
  localparam int CW = cnt_w(MAX_SECTORS);
  localparam int DW = dvd_w(MAX_SECTORS);

  cfg_t          cfg;
  logic          mod_start;
  logic [DW-1:0] mod_dividend;
  logic [CW-1:0] mod_divisor;
  logic          mod_done;
  logic [SW-1:0] mod_result;

  // configuration registers
  sis_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared remainder unit
  sis_mod_unit #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .result   (mod_result)
  );

  // sequencer, track state and output register
  sis_core #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .mod_start    (mod_start),
    .mod_dividend (mod_dividend),
    .mod_divisor  (mod_divisor),
    .mod_done     (mod_done),
    .mod_result   (mod_result)
  );

endmodule

// ===== tb/sv/sector_interleave_sequencer_test.sv =====
module sector_interleave_sequencer_test;
  import sis_pkg::*;

  // op code outside the enum, must leave the state alone
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] cyl;
    logic [3:0]  head;
  } track_item_t;

  typedef struct packed {
    logic [5:0]  sector;
    logic [21:0] lba;
    logic        done;
  } sector_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // cylinder [11:0], head_number [15:12]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // operation [1:0]
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // current_sector [5:0], block_address [27:6], zero [31:28]
  logic [OUT_DATA_W-1:0] m_tdata;
  // track_done
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sector_interleave_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register shadows
  logic [6:0] spt_reg   = SPT_RST;
  logic [5:0] step_reg  = STEP_RST;
  logic [5:0] skew_reg  = SKEW_RST;
  logic [4:0] heads_reg = HEADS_RST;

  // track state shadows
  logic [MAX_SECTORS_DEF-1:0] sector_used = '0;
  int sectors_filled = 0;
  int cur_sector = 0;
  int next_start = 0;

  track_item_t    feed_q[$];
  sector_result_t expected_q[$];
  track_item_t    sent_item;
  int queued_total = 0;
  int accepted_total = 0;
  int results_seen = 0;
  int fail_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [15:0] stall_pat = '1;
  int pat_left = 0;
  int cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("error at cycle %0d: %s", cycles, msg);
    fail_count++;
  endtask

  // applies one transaction to the shadow state and returns the sector it lands on
  function automatic sector_result_t next_sector(input track_item_t it);
    int n, hd, cur, k;
    longint blk;
    sector_result_t r;
    n = (spt_reg == 0) ? 1 : ((int'(spt_reg) > MAX_SECTORS_DEF) ? MAX_SECTORS_DEF
                                                                 : int'(spt_reg));
    hd = (int'(heads_reg) > MAX_HEADS) ? MAX_HEADS : int'(heads_reg);
    if (it.op == OP_NEW_CYL) begin
      next_start = 0;
    end else if (it.op == OP_NEW_TRACK) begin
      sector_used = '0;
      sectors_filled = 0;
      if (skew_reg == 0) begin
        cur_sector = 0;
      end else begin
        cur = next_start % n;
        cur_sector = cur;
        next_start = (cur + int'(skew_reg) % n) % n;
      end
    end else if (it.op == OP_ADVANCE) begin
      cur = cur_sector % n;
      sector_used[cur] = 1'b1;
      if (sectors_filled < n) sectors_filled++;
      // step by the interleave, then skip sectors already laid down
      if (sectors_filled < n) begin
        cur = (cur + int'(step_reg) % n) % n;
        for (k = 0; k < n && sector_used[cur]; k++) cur = (cur + 1) % n;
      end
      cur_sector = cur;
    end
    cur = cur_sector % n;
    blk = (longint'(it.cyl) * hd + longint'(it.head)) * n + cur;
    r.sector = cur[5:0];
    r.lba = blk[21:0];
    r.done = (sectors_filled >= n);
    return r;
  endfunction

  // input driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin : item_driver
    logic offering;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_q.push_back(next_sector(sent_item));
        accepted_total++;
        offering = 1'b0;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          sent_item = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {sent_item.head, sent_item.cyl};
          s_tuser <= sent_item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin : result_monitor
    sector_result_t want;
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("unexpected result, data %h done %b", m_tdata, m_tlast));
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[5:0] !== want.sector)
            report_error($sformatf("current_sector got %0d, expected %0d",
                                   m_tdata[5:0], want.sector));
          if (m_tdata[27:6] !== want.lba)
            report_error($sformatf("block_address got %0d, expected %0d",
                                   m_tdata[27:6], want.lba));
          if (m_tlast !== want.done)
            report_error($sformatf("track_done got %b, expected %b", m_tlast, want.done));
          if (m_tdata[31:28] !== 4'd0)
            report_error($sformatf("padding bits got %h", m_tdata[31:28]));
        end
        results_seen++;
        // one long hold-off so the block backs up onto its input
        if (!hold_done && results_seen >= HOLD_AFTER && feed_q.size() > 0) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (pat_left == 0) begin
          stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
          pat_left = 64;
        end
        pat_left--;
        rdy = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      m_tready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic [11:0] cyl,
                            input logic [3:0] head);
    track_item_t it;
    it.op = op;
    it.cyl = cyl;
    it.head = head;
    feed_q.push_back(it);
    queued_total++;
  endtask

  task automatic queue_random(input logic [1:0] op);
    queue_item(op, 12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)));
  endtask

  // write one register over apb, read it back and update the shadow
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    int w;
    logic [31:0] want;
    case (idx)
      REG_SPT: w = 7;
      REG_HEADS: w = 5;
      default: w = 6;
    endcase
    want = val & ((32'd1 << w) - 1);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SPT: spt_reg = want[6:0];
      REG_STEP: step_reg = want[5:0];
      REG_SKEW: skew_reg = want[5:0];
      REG_HEADS: heads_reg = want[4:0];
    endcase
    @(posedge clk);
    psel <= 1'b1;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      report_error($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int spt, input int step, input int skew, input int heads);
    write_reg(REG_SPT, spt);
    write_reg(REG_STEP, step);
    write_reg(REG_SKEW, skew);
    write_reg(REG_HEADS, heads);
  endtask

  // wait for every transaction to go in and every result to come out
  task automatic drain();
    while (accepted_total != queued_total) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int p, cnt, n, len, i, spt, step, skew, heads;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, field extremes and the unused op code
    queue_item(OP_NEW_CYL, 12'hFFF, 4'hF);
    queue_item(OP_NEW_TRACK, 12'h000, 4'h0);
    queue_item(OP_ADVANCE, 12'hFFF, 4'hF);
    queue_item(OP_UNUSED, 12'h000, 4'h0);
    drain();

    // step and skew above the sector count, head count clamped, full-track saturation
    set_config(3, 5, 4, 31);
    queue_item(OP_NEW_CYL, 12'hFFF, 4'hF);
    queue_item(OP_NEW_TRACK, 12'h555, 4'h5);
    for (i = 0; i < 4; i++) queue_item(OP_ADVANCE, 12'hAAA, 4'hA);
    queue_item(OP_NEW_TRACK, 12'hFFF, 4'h0);
    queue_item(OP_ADVANCE, 12'h000, 4'hF);
    queue_item(OP_NEW_TRACK, 12'h0F0, 4'h3);
    queue_item(OP_UNUSED, 12'hFFF, 4'hF);
    drain();

    // sector count of zero and no heads, changed mid-track
    set_config(0, 1, 1, 0);
    queue_item(OP_ADVANCE, 12'hFFF, 4'hF);
    queue_item(OP_ADVANCE, 12'h123, 4'h9);
    queue_item(OP_NEW_TRACK, 12'hFFF, 4'hF);
    queue_item(OP_ADVANCE, 12'hFFF, 4'hF);
    drain();

    // random phases over a spread of settings, extremes first
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin spt = 64; step = 63; skew = 63; heads = 16; end
        1: begin spt = 1; step = 0; skew = 0; heads = 1; end
        2: begin spt = 2; step = 1; skew = 1; heads = 31; end
        3: begin spt = 127; step = 0; skew = 5; heads = 0; end
        4: begin spt = 9; step = 63; skew = 0; heads = 8; end
        7: begin
          spt = $urandom_range(0, 127);
          step = $urandom_range(0, 63);
          skew = $urandom_range(0, 63);
          heads = $urandom_range(0, 31);
        end
        default: begin
          spt = $urandom_range(1, 20);
          step = $urandom_range(0, 63);
          skew = $urandom_range(0, 63);
          heads = $urandom_range(0, 31);
        end
      endcase
      set_config(spt, step, skew, heads);
      n = (spt == 0) ? 1 : ((spt > MAX_SECTORS_DEF) ? MAX_SECTORS_DEF : spt);
      cnt = 0;
      while (cnt < 135) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any op code, including the unused one
          len = $urandom_range(1, 4);
          for (i = 0; i < len; i++) queue_random(2'($urandom_range(0, 3)));
          cnt += len;
        end else begin
          // well-formed track: optional new cylinder, new track, run of advances
          if ($urandom_range(0, 3) == 0) begin
            queue_random(OP_NEW_CYL);
            cnt++;
          end
          queue_random(OP_NEW_TRACK);
          len = $urandom_range(1, n + 3);
          for (i = 0; i < len; i++) queue_random(OP_ADVANCE);
          cnt += len + 1;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
